FILE: hdl/satq_pkg.sv
// Shared types and constants for the summed-area table query unit.
// No dependencies; imported by the top level and its checker.
package satq_pkg;

	// Fixed field widths
	localparam int VAL_W = 16;	// element word
	localparam int SUM_W = 28;	// prefix/result word, wraps modulo 2^SUM_W
	localparam int IDX_W = 6;	// rectangle corner fields
	localparam int CFG_W = 7;	// config data word

	typedef enum logic {
		OP_LOAD  = 1'b0,
		OP_QUERY = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_BAD_RECT   = 2'd1,
		ST_INCOMPLETE = 2'd2
	} status_t;

	// Config register indexes
	localparam logic CFG_ROWS = 1'b0;
	localparam logic CFG_COLS = 1'b1;

	typedef logic signed [SUM_W-1:0] sum_t;

	// Sign-extend an element word into the prefix width
	function automatic sum_t sext_val(input logic signed [VAL_W-1:0] v);
		return SUM_W'(v);
	endfunction

endpackage

FILE: hdl/satq_ram.sv
// Generic single-port RAM, one access per cycle, registered read data.
// No dependencies.
module satq_ram #(
	parameter int WIDTH = 28,
	parameter int DEPTH = 4096,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             en,
	input  logic             we,
	input  logic [AW-1:0]    addr,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end

endmodule

FILE: hdl/summed_area_table_query_unit.sv
// Summed-area table query unit: a load steps through S_LD_RD, S_LD_ACC and S_LD_WR before done,
// a query reads its corners in S_QRY, and a query that fails its checks answers from S_IDLE;
// the next word is accepted once busy drops. The single table port serves one corner read per
// cycle for a query, and for a load a read of the entry above followed by its write-back.
// Reset (arst_n low): 64 x 64, load position (0,0), running sum zero, table incomplete;
// table contents undefined until loaded. done strobes one cycle; the receiver cannot stall.
module summed_area_table_query_unit
	import satq_pkg::*;
#(
	parameter int MAX_ROWS = 64,
	parameter int MAX_COLS = 64
) (
	input  logic                     clk,
	input  logic                     arst_n,
	// command side
	input  logic                     start,
	output logic                     busy,
	input  logic                     opcode,
	input  logic signed [VAL_W-1:0]  element_value,
	input  logic        [IDX_W-1:0]  top_row,
	input  logic        [IDX_W-1:0]  left_col,
	input  logic        [IDX_W-1:0]  bottom_row,
	input  logic        [IDX_W-1:0]  right_col,
	// config write port
	input  logic                     cfg_we,
	input  logic                     cfg_index,
	input  logic        [CFG_W-1:0]  cfg_data,
	// result side
	output logic                     done,
	output logic signed [SUM_W-1:0]  result_value,
	output logic        [1:0]        status
);

	localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int DROW_W = $clog2(MAX_ROWS + 1);
	localparam int DCOL_W = $clog2(MAX_COLS + 1);
	localparam int DEPTH  = MAX_ROWS * MAX_COLS;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [ROW_W-1:0] ROW_ONE = ROW_W'(1);
	localparam logic [COL_W-1:0] COL_ONE = COL_W'(1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_LD_RD,
		S_LD_ACC,
		S_LD_WR,
		S_QRY
	} state_t;

	state_t              state_q;
	logic [DROW_W-1:0]   rows_q;
	logic [DCOL_W-1:0]   cols_q;
	logic [ROW_W-1:0]    row_q;
	logic [COL_W-1:0]    col_q;
	sum_t                running_q;
	logic                complete_q;
	sum_t                acc_q;
	logic                acc_en_q;
	logic                acc_sub_q;
	logic [2:0]          step_q;
	logic [IDX_W-1:0]    t_q, l_q, b_q, r_q;
	logic                done_q;
	sum_t                result_q;
	status_t             status_q;

	logic                accept;
	logic                restart;
	sum_t                run_new;
	status_t             q_status;
	logic                col_last, row_last;
	logic [ROW_W-1:0]    row_sel;
	logic [COL_W-1:0]    col_sel;
	logic [ADDR_W-1:0]   mem_addr;
	logic                mem_en, mem_we;
	logic [SUM_W-1:0]    mem_rdata;
	logic                corner_ok;
	sum_t                acc_next;
	logic [DROW_W-1:0]   rows_cfg;
	logic [DCOL_W-1:0]   cols_cfg;

	assign accept = start && (state_q == S_IDLE);
	assign busy   = (state_q != S_IDLE);

	// Clamp config values: 0 acts as 1, above the maximum acts as the maximum
	always_comb begin
		if (cfg_data == '0) begin
			rows_cfg = DROW_W'(1);
			cols_cfg = DCOL_W'(1);
		end else begin
			rows_cfg = (32'(cfg_data) > MAX_ROWS) ? DROW_W'(MAX_ROWS) : DROW_W'(cfg_data);
			cols_cfg = (32'(cfg_data) > MAX_COLS) ? DCOL_W'(MAX_COLS) : DCOL_W'(cfg_data);
		end
	end

	// Load: position out of range restarts at (0,0) with a fresh running sum
	assign restart = (32'(row_q) >= 32'(rows_q)) || (32'(col_q) >= 32'(cols_q));
	assign run_new = (restart ? sum_t'(0) : running_q) + sext_val(element_value);
	assign col_last = (32'(col_q) + 1) >= 32'(cols_q);
	assign row_last = (32'(row_q) + 1) >= 32'(rows_q);

	// Query checks; an incomplete table wins over a bad rectangle
	always_comb begin
		if (!complete_q) begin
			q_status = ST_INCOMPLETE;
		end else if ((top_row > bottom_row) || (left_col > right_col) ||
			(32'(bottom_row) >= 32'(rows_q)) || (32'(right_col) >= 32'(cols_q))) begin
			q_status = ST_BAD_RECT;
		end else begin
			q_status = ST_OK;
		end
	end

	// Table address select: entry above for a load read, own entry for the write,
	// corner k for a query (bit 0 picks top-1 row, bit 1 picks left-1 column)
	always_comb begin
		unique case (state_q)
			S_LD_RD: begin
				row_sel = row_q - ROW_ONE;
				col_sel = col_q;
			end
			S_QRY: begin
				row_sel = step_q[0] ? (ROW_W'(t_q) - ROW_ONE) : ROW_W'(b_q);
				col_sel = step_q[1] ? (COL_W'(l_q) - COL_ONE) : COL_W'(r_q);
			end
			default: begin
				row_sel = row_q;
				col_sel = col_q;
			end
		endcase
	end

	assign mem_addr = ADDR_W'(ADDR_W'(row_sel) * MAX_COLS) + ADDR_W'(col_sel);
	assign mem_we   = (state_q == S_LD_WR);
	assign mem_en   = mem_we || ((state_q == S_LD_RD) && (row_q != '0)) ||
		((state_q == S_QRY) && !step_q[2]);

	// Corners on row -1 or column -1 read as zero: skip them
	assign corner_ok = !step_q[2] && (!step_q[0] || (t_q != '0)) &&
		(!step_q[1] || (l_q != '0));

	// Shared add/subtract unit
	always_comb begin
		if (!acc_en_q) begin
			acc_next = acc_q;
		end else if (acc_sub_q) begin
			acc_next = acc_q - sum_t'(mem_rdata);
		end else begin
			acc_next = acc_q + sum_t'(mem_rdata);
		end
	end

	satq_ram #(
		.WIDTH(SUM_W),
		.DEPTH(DEPTH)
	) u_table (
		.clk   (clk),
		.en    (mem_en),
		.we    (mem_we),
		.addr  (mem_addr),
		.wdata (acc_q),
		.rdata (mem_rdata)
	);

	// Sequencer, load position, config and registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			rows_q     <= DROW_W'(MAX_ROWS);
			cols_q     <= DCOL_W'(MAX_COLS);
			row_q      <= '0;
			col_q      <= '0;
			running_q  <= '0;
			complete_q <= 1'b0;
			acc_en_q   <= 1'b0;
			acc_sub_q  <= 1'b0;
			step_q     <= '0;
			done_q     <= 1'b0;
		end else begin
			done_q <= 1'b0;

			if (cfg_we) begin
				unique case (cfg_index)
					CFG_ROWS: rows_q <= rows_cfg;
					CFG_COLS: cols_q <= cols_cfg;
				endcase
				row_q      <= '0;
				col_q      <= '0;
				running_q  <= '0;
				complete_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (opcode == OP_LOAD) begin
							running_q <= run_new;
							acc_q     <= run_new;
							acc_en_q  <= !restart && (row_q != '0);
							acc_sub_q <= 1'b0;
							if (restart) begin
								row_q <= '0;
								col_q <= '0;
							end
							state_q <= S_LD_RD;
						end else begin
							t_q       <= top_row;
							l_q       <= left_col;
							b_q       <= bottom_row;
							r_q       <= right_col;
							acc_q     <= '0;
							acc_en_q  <= 1'b0;
							acc_sub_q <= 1'b0;
							step_q    <= '0;
							if (q_status != ST_OK) begin
								done_q   <= 1'b1;
								result_q <= '0;
								status_q <= q_status;
							end else begin
								state_q <= S_QRY;
							end
						end
					end
				end
				S_LD_RD: begin
					state_q <= S_LD_ACC;
				end
				S_LD_ACC: begin
					acc_q    <= acc_next;
					acc_en_q <= 1'b0;
					state_q  <= S_LD_WR;
				end
				S_LD_WR: begin
					done_q     <= 1'b1;
					result_q   <= acc_q;
					status_q   <= ST_OK;
					complete_q <= col_last && row_last;
					if (col_last) begin
						col_q     <= '0;
						running_q <= '0;
						row_q     <= row_last ? '0 : row_q + ROW_ONE;
					end else begin
						col_q <= col_q + COL_ONE;
					end
					state_q <= S_IDLE;
				end
				S_QRY: begin
					acc_q     <= acc_next;
					acc_en_q  <= corner_ok;
					acc_sub_q <= step_q[0] ^ step_q[1];
					step_q    <= step_q + 3'd1;
					if (step_q[2]) begin
						done_q   <= 1'b1;
						result_q <= acc_next;
						status_q <= ST_OK;
						state_q  <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign done         = done_q;
	assign result_value = result_q;
	assign status       = status_q;

endmodule

FILE: hdl/satq_checker.sv
// Port-level checks for the summed-area table query unit, bound to the top level.
// Depends on satq_pkg for the status codes.
module satq_checker
	import satq_pkg::*;
(
	input logic                    clk,
	input logic                    arst_n,
	input logic                    start,
	input logic                    busy,
	input logic                    done,
	input logic signed [SUM_W-1:0] result_value,
	input logic        [1:0]       status
);

	// A result word only shows once the unit is free again
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("done strobe while busy");

	// An accepted command either starts work or answers at once
	a_accept_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy || done))
		else $error("accepted command produced neither work nor result");

	// No result word appears out of nowhere
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		(!busy && !start) |=> !done)
		else $error("result strobe without a command");

	// Failed commands return zero with a known error code
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status != ST_OK)) |->
			((result_value == '0) && ((status == ST_BAD_RECT) || (status == ST_INCOMPLETE))))
		else $error("error result not zero or bad status code");

endmodule

bind summed_area_table_query_unit satq_checker u_satq_checker (.*);

FILE: tb/summed_area_table_query_unit_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for summed_area_table_query_unit: loads matrices, asks rectangle sums,
// and compares every done word with a local prefix-sum predictor. Needs hdl/satq_pkg.sv.
module summed_area_table_query_unit_tb;
	import satq_pkg::*;

	localparam int TB_MAX = 64;
	localparam int N_ITEMS = 1850;

	typedef struct {
		sum_t    value;
		status_t st;
	} sat_answer_t;

	logic                    clk = 1'b0;
	logic                    arst_n;
	logic                    start;
	logic                    busy;
	logic                    opcode;
	logic signed [VAL_W-1:0] element_value;
	logic        [IDX_W-1:0] top_row;
	logic        [IDX_W-1:0] left_col;
	logic        [IDX_W-1:0] bottom_row;
	logic        [IDX_W-1:0] right_col;
	logic                    cfg_we;
	logic                    cfg_index;
	logic        [CFG_W-1:0] cfg_data;
	logic                    done;
	logic signed [SUM_W-1:0] result_value;
	logic        [1:0]       status;

	// Predictor state: prefix table, load position, running row sum, dimensions
	sum_t prefix_mem [TB_MAX][TB_MAX];
	sum_t run_sum;
	int   pos_row;
	int   pos_col;
	int   dim_rows;
	int   dim_cols;
	bit   mat_done;

	sat_answer_t pending_answers[$];
	int  mismatch_count = 0;
	int  checked_words = 0;
	int  load_words = 0;
	int  query_words = 0;
	bit  gaps_on = 1'b0;

	summed_area_table_query_unit u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.opcode       (opcode),
		.element_value(element_value),
		.top_row      (top_row),
		.left_col     (left_col),
		.bottom_row   (bottom_row),
		.right_col    (right_col),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.done         (done),
		.result_value (result_value),
		.status       (status)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic void restart_position();
		run_sum = '0;
		pos_row = 0;
		pos_col = 0;
		mat_done = 1'b0;
	endfunction

	// Effective dimension of a raw register value: 0 acts as 1, large values as the maximum
	function automatic int eff_dim(logic [CFG_W-1:0] raw);
		return (raw == 0) ? 1 : (raw > TB_MAX) ? TB_MAX : int'(raw);
	endfunction

	// Expected answer for one word; updates the table on loads
	function automatic sat_answer_t integral_step(op_t op, logic signed [VAL_W-1:0] v,
			logic [IDX_W-1:0] t, logic [IDX_W-1:0] l, logic [IDX_W-1:0] b,
			logic [IDX_W-1:0] r);
		sat_answer_t a;
		sum_t above;
		a.value = '0;
		a.st = ST_OK;
		if (op == OP_LOAD) begin
			if (pos_row >= dim_rows || pos_col >= dim_cols)
				restart_position();
			run_sum = run_sum + {{(SUM_W-VAL_W){v[VAL_W-1]}}, v};
			above = (pos_row > 0) ? prefix_mem[pos_row-1][pos_col] : '0;
			a.value = above + run_sum;
			prefix_mem[pos_row][pos_col] = a.value;
			mat_done = 1'b0;
			if (pos_col + 1 >= dim_cols) begin
				pos_col = 0;
				run_sum = '0;
				if (pos_row + 1 >= dim_rows) begin
					pos_row = 0;
					mat_done = 1'b1;
				end else begin
					pos_row++;
				end
			end else begin
				pos_col++;
			end
		end else if (!mat_done) begin
			a.st = ST_INCOMPLETE;
		end else if (t > b || l > r || b >= dim_rows || r >= dim_cols) begin
			a.st = ST_BAD_RECT;
		end else begin
			// four-corner sum, row or column -1 reads as zero
			a.value = prefix_mem[b][r];
			if (t > 0)
				a.value = a.value - prefix_mem[t-1][r];
			if (l > 0)
				a.value = a.value - prefix_mem[b][l-1];
			if (t > 0 && l > 0)
				a.value = a.value + prefix_mem[t-1][l-1];
		end
		return a;
	endfunction

	function automatic logic signed [VAL_W-1:0] rand_element();
		case ($urandom_range(0, 7))
			0: return 16'sh7FFF;
			1: return 16'sh8000;
			2: return '0;
			default: return VAL_W'($urandom);
		endcase
	endfunction

	function automatic logic [CFG_W-1:0] pick_dim_raw();
		case ($urandom_range(0, 19))
			0: return '0;
			1: return CFG_W'($urandom_range(65, 127));
			2, 3, 4: return CFG_W'($urandom_range(9, 24));
			default: return CFG_W'($urandom_range(1, 8));
		endcase
	endfunction

	// Sender gaps: random bursts, fields left as noise while start is low
	task automatic idle_cycles(int n);
		repeat (n) begin
			start <= 1'b0;
			opcode <= 1'($urandom);
			element_value <= VAL_W'($urandom);
			top_row <= IDX_W'($urandom);
			left_col <= IDX_W'($urandom);
			bottom_row <= IDX_W'($urandom);
			right_col <= IDX_W'($urandom);
			@(negedge clk);
		end
	endtask

	// Present one word; start stays high on return so back-to-back words need no gap
	task automatic send_word(op_t op, logic signed [VAL_W-1:0] v, logic [IDX_W-1:0] t,
			logic [IDX_W-1:0] l, logic [IDX_W-1:0] b, logic [IDX_W-1:0] r);
		if (gaps_on && $urandom_range(0, 5) == 0)
			idle_cycles($urandom_range(1, 10));
		start <= 1'b1;
		opcode <= op;
		element_value <= v;
		top_row <= t;
		left_col <= l;
		bottom_row <= b;
		right_col <= r;
		do @(posedge clk); while (busy);
		pending_answers.push_back(integral_step(op, v, t, l, b, r));
		if (op == OP_LOAD)
			load_words++;
		else
			query_words++;
		@(negedge clk);
	endtask

	task automatic load_word(logic signed [VAL_W-1:0] v);
		send_word(OP_LOAD, v, IDX_W'($urandom), IDX_W'($urandom), IDX_W'($urandom),
			IDX_W'($urandom));
	endtask

	task automatic query_rect(int t, int l, int b, int r);
		send_word(OP_QUERY, VAL_W'($urandom), IDX_W'(t), IDX_W'(l), IDX_W'(b), IDX_W'(r));
	endtask

	// Finish the matrix from the current load position; random fills mix in an odd random query
	task automatic fill_matrix(bit use_fixed, logic signed [VAL_W-1:0] fixed_v);
		int left_to_load;
		left_to_load = dim_rows * dim_cols - (pos_row * dim_cols + pos_col);
		repeat (left_to_load) begin
			if (!use_fixed && $urandom_range(0, 24) == 0)
				query_rect($urandom, $urandom, $urandom, $urandom);
			load_word(use_fixed ? fixed_v : rand_element());
		end
	endtask

	task automatic random_query();
		logic [IDX_W-1:0] t, l, b, r;
		t = IDX_W'($urandom_range(0, dim_rows - 1));
		b = IDX_W'($urandom_range(t, dim_rows - 1));
		l = IDX_W'($urandom_range(0, dim_cols - 1));
		r = IDX_W'($urandom_range(l, dim_cols - 1));
		case ($urandom_range(0, 9))
			7: begin
				t = IDX_W'($urandom);
				l = IDX_W'($urandom);
				b = IDX_W'($urandom);
				r = IDX_W'($urandom);
			end
			// reversed rectangle
			8: begin
				if (b > t)
					{t, b} = {b, t};
				else if (r > l)
					{l, r} = {r, l};
			end
			// corner past the loaded size
			9: begin
				if (dim_rows < TB_MAX)
					b = IDX_W'($urandom_range(dim_rows, TB_MAX - 1));
				else if (dim_cols < TB_MAX)
					r = IDX_W'($urandom_range(dim_cols, TB_MAX - 1));
			end
			default: ;
		endcase
		send_word(OP_QUERY, VAL_W'($urandom), t, l, b, r);
	endtask

	// Drop start and wait until every word has come back and the block is idle
	task automatic drain();
		start <= 1'b0;
		do @(negedge clk); while (pending_answers.size() != 0 || busy);
	endtask

	task automatic write_reg(logic idx, logic [CFG_W-1:0] data);
		int eff;
		drain();
		eff = eff_dim(data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		if (idx == CFG_ROWS)
			dim_rows = eff;
		else
			dim_cols = eff;
		restart_position();
		@(negedge clk);
		cfg_we <= 1'b0;
		cfg_index <= 1'($urandom);
		cfg_data <= CFG_W'($urandom);
	endtask

	// Queries before any load: incomplete wins over a bad rectangle
	task automatic test_empty_table();
		gaps_on = 1'b0;
		query_rect(0, 0, TB_MAX - 1, TB_MAX - 1);
		query_rect(5, 0, 2, 0);
	endtask

	// Reset row count with three columns, filled with the most negative element
	task automatic test_full_table_minimum();
		gaps_on = 1'b0;
		write_reg(CFG_COLS, 7'd3);
		fill_matrix(1'b1, 16'sh8000);
		query_rect(0, 0, 63, 2);
		query_rect(63, 2, 63, 2);
		query_rect(0, 0, 0, 0);
		query_rect(10, 1, 9, 1);
		query_rect(0, 0, 63, 3);
	endtask

	// Oversized register values act as 64; fill with the largest element
	task automatic test_clamped_dims_maximum();
		gaps_on = 1'b0;
		write_reg(CFG_ROWS, 7'd127);
		write_reg(CFG_COLS, 7'd2);
		fill_matrix(1'b1, 16'sh7FFF);
		query_rect(0, 0, 63, 1);
		query_rect(20, 1, 40, 1);
		write_reg(CFG_ROWS, 7'd2);
		write_reg(CFG_COLS, 7'd127);
		fill_matrix(1'b1, 16'sh7FFF);
		query_rect(0, 0, 1, 63);
		query_rect(1, 30, 1, 50);
		load_word(rand_element());
		query_rect(0, 0, 0, 0);
	endtask

	// Zero register values act as 1: every load completes a 1 x 1 table
	task automatic test_single_cell();
		gaps_on = 1'b1;
		write_reg(CFG_ROWS, 7'd0);
		write_reg(CFG_COLS, 7'd0);
		load_word(rand_element());
		query_rect(0, 0, 0, 0);
		query_rect(1, 0, 1, 0);
		query_rect(0, 0, 0, 1);
		query_rect(63, 63, 63, 63);
		load_word(rand_element());
		query_rect(0, 0, 0, 0);
	endtask

	// A register write in mid-matrix restarts loading; edges of the table
	task automatic test_restart_on_write();
		gaps_on = 1'b1;
		write_reg(CFG_ROWS, 7'd3);
		write_reg(CFG_COLS, 7'd5);
		repeat (7) load_word(rand_element());
		query_rect(0, 0, 2, 4);
		write_reg(CFG_COLS, 7'd4);
		fill_matrix(1'b0, '0);
		query_rect(0, 0, 2, 3);
		query_rect(2, 3, 2, 3);
		query_rect(1, 1, 1, 1);
		query_rect(0, 0, 3, 3);
		query_rect(0, 0, 2, 4);
	endtask

	// Random shapes, well-formed matrices with random content, then mostly valid queries
	task automatic test_random_traffic();
		logic [CFG_W-1:0] cols_raw;
		while (load_words + query_words < N_ITEMS) begin
			write_reg(CFG_ROWS, pick_dim_raw());
			cols_raw = pick_dim_raw();
			// keep each matrix small so the word count stays near the budget
			if (dim_rows * eff_dim(cols_raw) > 128)
				cols_raw = CFG_W'($urandom_range(0, 128 / dim_rows));
			write_reg(CFG_COLS, cols_raw);
			// no gaps in the closing stretch, and none in some phases
			gaps_on = ($urandom_range(0, 3) != 0) &&
				(load_words + query_words < N_ITEMS - 300);
			repeat ($urandom_range(1, 2)) begin
				fill_matrix(1'b0, '0);
				repeat ($urandom_range(2, 8)) random_query();
			end
		end
	endtask

	// Result checker: each done word against the oldest expected answer
	always @(posedge clk) begin : check_results
		sat_answer_t want;
		if (arst_n && done) begin
			if (pending_answers.size() == 0) begin
				mismatch_count++;
				$display("%0t: done word with nothing expected: result_value %0d status %0d",
					$time, result_value, status);
			end else begin
				want = pending_answers.pop_front();
				checked_words++;
				if (result_value !== want.value) begin
					mismatch_count++;
					$display("%0t: result_value expected %0d actual %0d",
						$time, want.value, result_value);
				end
				if (status !== want.st) begin
					mismatch_count++;
					$display("%0t: status expected %0d actual %0d",
						$time, want.st, status);
				end
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		opcode = OP_LOAD;
		element_value = '0;
		top_row = '0;
		left_col = '0;
		bottom_row = '0;
		right_col = '0;
		cfg_we = 1'b0;
		cfg_index = CFG_ROWS;
		cfg_data = '0;
		dim_rows = TB_MAX;
		dim_cols = TB_MAX;
		restart_position();
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_empty_table();
		test_full_table_minimum();
		test_clamped_dims_maximum();
		test_single_cell();
		test_restart_on_write();
		test_random_traffic();

		drain();
		repeat (10) @(posedge clk);
		$display("Run covered %0d loads and %0d rectangle queries, %0d words checked,",
			load_words, query_words, checked_words);
		$display("tables from 1 x 1 up to 64 rows or 64 columns, including register clamping.");
		if (mismatch_count == 0 && pending_answers.size() == 0)
			$display("** summed_area_table_query_unit: PASSED **");
		else
			$display("** summed_area_table_query_unit: FAILED **");
		$finish;
	end

	// Watchdog
	initial begin
		#20_000_000;
		$display("Timeout with %0d words still expected", pending_answers.size());
		$display("** summed_area_table_query_unit: FAILED **");
		$finish;
	end

endmodule
